// ===== hdl/bbce_pkg.sv =====
// ----------------------------------------------------------------------------
// bbce_pkg: shared types and constants
// Sequencer states, the exp(-2^(k-12)) table and the fixed-point
// constants of the balanced cross-entropy loss and gradient block.
// ----------------------------------------------------------------------------
`default_nettype none

package bbce_pkg;

  localparam int DIV_NUM_W = 40;
  localparam int DIV_DEN_W = 18;

  localparam logic [15:0] LN2_Q16       = 16'd45426;
  localparam logic [20:0] LOSS_MAX      = 21'h1FFFFF;
  localparam logic [16:0] EXP_ONE       = 17'h10000;
  localparam logic [15:0] POS_THRESHOLD = 16'd16384;

  typedef enum logic [4:0] {
    S_IDLE,
    S_RD,
    S_LD,
    S_EXP,
    S_EXPW,
    S_SIGS,
    S_SIGW,
    S_LNM,
    S_LNA,
    S_LNF,
    S_LNR,
    S_ZYR,
    S_LOSS,
    S_L2,
    S_L3,
    S_L4,
    S_LDIV,
    S_LWAIT,
    S_GRD,
    S_GLD,
    S_GW,
    S_GOUT
  } state_t;

  // exp(-2^(k-12)) in Q0.16
  function automatic logic [15:0] exp_tab(input logic [3:0] k);
    logic [15:0] r;
    case (k)
      4'd0:    r = 16'd65520;
      4'd1:    r = 16'd65504;
      4'd2:    r = 16'd65472;
      4'd3:    r = 16'd65408;
      4'd4:    r = 16'd65280;
      4'd5:    r = 16'd65026;
      4'd6:    r = 16'd64520;
      4'd7:    r = 16'd63520;
      4'd8:    r = 16'd61565;
      4'd9:    r = 16'd57835;
      4'd10:   r = 16'd51039;
      4'd11:   r = 16'd39750;
      4'd12:   r = 16'd24109;
      4'd13:   r = 16'd8869;
      4'd14:   r = 16'd1200;
      default: r = 16'd22;
    endcase
    return r;
  endfunction

endpackage

`default_nettype wire

// ===== hdl/balanced_bce_logits_loss_grad.sv =====
// ----------------------------------------------------------------------------
// balanced_bce_logits_loss_grad: class-balanced BCE-with-logits loss/gradient
// Collects a batch of (logit, target) pairs, then emits one gradient per
// element, each carrying the weighted mean loss of the batch.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid/in_ready, logit, target, last_element): one
//   transaction per element, taken while the block is loading.
//   The element flagged last, or the one that fills MAX_BATCH, closes the
//   batch; in_ready then stays low until every gradient has been taken.
//   Closing runs a pass over the stored batch: per element an exp step
//   for each bit of |z| plus a multiply per set bit, the sigmoid division
//   and, unless z is zero, the squarings for log2, all on one shared
//   32x32 multiplier and one bit-serial divider, then the loss division,
//   which is skipped when the weighted sum is negative.
//   Output channel (out_valid/out_ready, gradient, mean_loss, element_index,
//   last_result): gradients leave in element order, each after a read and a
//   division on the same divider; each starts only after the previous gradient is taken.
//   A stalled receiver holds the current result in its register.
//   Reset (rst, synchronous) empties the batch and returns to loading.
// ----------------------------------------------------------------------------
`default_nettype none

module balanced_bce_logits_loss_grad
  import bbce_pkg::*;
#(
  parameter int MAX_BATCH = 32
) (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               in_valid,
  output logic                    in_ready,
  input  wire logic signed [15:0] logit,
  input  wire logic        [15:0] target,
  input  wire logic               last_element,
  output logic                    out_valid,
  input  wire logic               out_ready,
  output logic signed [17:0]      gradient,
  output logic        [20:0]      mean_loss,
  output logic        [5:0]       element_index,
  output logic                    last_result
);

  localparam int AW = (MAX_BATCH > 1) ? $clog2(MAX_BATCH) : 1;
  localparam int CW = $clog2(MAX_BATCH + 1);

  state_t state, state_next;

  // batch bookkeeping
  logic [CW-1:0] count;
  logic [CW-1:0] tally;
  logic [CW-1:0] n;
  logic [CW-1:0] i;
  logic [CW-1:0] q;
  logic          balanced;
  logic          in_acc;
  logic          closing;

  // element datapath
  logic signed [15:0] z;
  logic        [15:0] y;
  logic        [15:0] a;
  logic        [3:0]  k;
  logic        [16:0] ev;
  logic        [31:0] lv;
  logic        [15:0] lbits;
  logic        [3:0]  j;
  logic        [15:0] ln;
  logic signed [31:0] spos, sneg;
  logic signed [39:0] acc;
  logic        [17:0] lden;
  logic        [20:0] loss;
  logic signed [17:0] grad;
  logic               dneg;

  // shared multiplier
  logic [31:0] ma, mb;
  logic [63:0] mres;
  logic [63:0] rnd16;
  logic [63:0] rnd11;
  logic [31:0] sq;

  // divider
  logic                 div_start;
  logic [DIV_NUM_W-1:0] div_num;
  logic [DIV_DEN_W-1:0] div_den;
  logic                 div_done;
  logic [DIV_NUM_W:0]   div_quo;

  // stores
  logic          st_we;
  logic [AW-1:0] st_waddr;
  logic [31:0]   st_rdata;
  logic          sig_we;
  logic [16:0]   sig_rdata;

  logic signed [31:0] sp, zys, term;
  logic        [20:0] zym;
  logic        [31:0] spos_mag, sneg_mag;
  logic signed [18:0] d;
  logic               g_pos;
  logic        [17:0] gden;

  assign in_ready = (state == S_IDLE);
  assign in_acc   = in_valid && in_ready;
  assign closing  = last_element || (count + CW'(1) == CW'(MAX_BATCH));

  assign q        = n - tally;
  assign balanced = (tally != '0) && (tally != n);

  assign rnd16 = mres + 64'd32768;
  assign rnd11 = mres + 64'd1024;
  assign sq    = mres[61:30];

  assign zym  = rnd11[31:11];
  assign sp   = 32'(ln) + ((!z[15] && (z != 16'sd0)) ? (32'(z) <<< 4) : 32'sd0);
  assign zys  = z[15] ? -32'($signed({1'b0, zym})) : 32'($signed({1'b0, zym}));
  assign term = sp - zys;

  assign spos_mag = spos[31] ? 32'(-spos) : 32'(spos);
  assign sneg_mag = sneg[31] ? 32'(-sneg) : 32'(sneg);

  assign d     = $signed({2'b00, sig_rdata}) - $signed({2'b00, st_rdata[15:0], 1'b0});
  assign g_pos = (st_rdata[15:0] > POS_THRESHOLD);
  assign gden  = balanced ? 18'({(g_pos ? tally : q), 1'b0}) : 18'(n);

  assign st_we    = in_acc;
  assign st_waddr = count[AW-1:0];
  assign sig_we   = (state == S_SIGW) && div_done;

  bbce_ram #(.WIDTH(32), .DEPTH(MAX_BATCH)) u_store (
    .clk   (clk),
    .we    (st_we),
    .waddr (st_waddr),
    .wdata ({logit, target}),
    .raddr (i[AW-1:0]),
    .rdata (st_rdata)
  );

  bbce_ram #(.WIDTH(17), .DEPTH(MAX_BATCH)) u_sig (
    .clk   (clk),
    .we    (sig_we),
    .waddr (i[AW-1:0]),
    .wdata (div_quo[16:0]),
    .raddr (i[AW-1:0]),
    .rdata (sig_rdata)
  );

  bbce_div #(.NUM_W(DIV_NUM_W), .DEN_W(DIV_DEN_W)) u_div (
    .clk   (clk),
    .rst   (rst),
    .start (div_start),
    .num   (div_num),
    .den   (div_den),
    .done  (div_done),
    .quo   (div_quo)
  );

  always_ff @(posedge clk) begin
    mres <= 64'(ma) * 64'(mb);
  end

  // next state
  always_comb begin
    state_next = state;
    case (state)
      S_IDLE:  if (in_acc && closing) state_next = S_RD;
      S_RD:    state_next = S_LD;
      S_LD:    state_next = S_EXP;
      S_EXP: begin
        if (a[k])             state_next = S_EXPW;
        else if (k == 4'd15)  state_next = S_SIGS;
      end
      S_EXPW:  state_next = (k == 4'd15) ? S_SIGS : S_EXP;
      S_SIGS:  state_next = S_SIGW;
      S_SIGW:  if (div_done) state_next = (ev == EXP_ONE) ? S_LNF : S_LNM;
      S_LNM:   state_next = S_LNA;
      S_LNA:   state_next = (j == 4'd15) ? S_LNF : S_LNM;
      S_LNF:   state_next = S_LNR;
      S_LNR:   state_next = S_ZYR;
      S_ZYR:   state_next = (i + CW'(1) == n) ? S_LOSS : S_RD;
      S_LOSS:  state_next = balanced ? S_L2 : S_LDIV;
      S_L2:    state_next = S_L3;
      S_L3:    state_next = S_L4;
      S_L4:    state_next = S_LDIV;
      S_LDIV:  state_next = acc[39] ? S_GRD : S_LWAIT;
      S_LWAIT: if (div_done) state_next = S_GRD;
      S_GRD:   state_next = S_GLD;
      S_GLD:   state_next = S_GW;
      S_GW:    if (div_done) state_next = S_GOUT;
      S_GOUT: begin
        if (out_ready) state_next = (i + CW'(1) == n) ? S_IDLE : S_GRD;
      end
      default: state_next = S_IDLE;
    endcase
  end

  // multiplier operands and divider requests
  always_comb begin
    ma        = '0;
    mb        = '0;
    div_start = 1'b0;
    div_num   = '0;
    div_den   = '0;
    case (state)
      S_EXP: begin
        ma = 32'(ev);
        mb = 32'(exp_tab(k));
      end
      S_LNM: begin
        ma = lv;
        mb = lv;
      end
      S_LNF: begin
        ma = 32'(lbits);
        mb = 32'(LN2_Q16);
      end
      S_LNR: begin
        ma = 32'(a);
        mb = 32'(y);
      end
      S_LOSS: begin
        ma = spos_mag;
        mb = 32'(q);
      end
      S_L2: begin
        ma = sneg_mag;
        mb = 32'(tally);
      end
      S_L3: begin
        ma = 32'(tally);
        mb = 32'(q);
      end
      S_SIGS: begin
        div_start = 1'b1;
        div_num   = z[15] ? (DIV_NUM_W'(ev) << 16) : (DIV_NUM_W'(1) << 32);
        div_den   = DIV_DEN_W'(ev) + DIV_DEN_W'(EXP_ONE);
      end
      S_LDIV: begin
        div_start = !acc[39];
        div_num   = DIV_NUM_W'(acc);
        div_den   = lden;
      end
      S_GLD: begin
        div_start = 1'b1;
        div_num   = d[18] ? DIV_NUM_W'(-d) : DIV_NUM_W'(d);
        div_den   = gden;
      end
      default: begin
      end
    endcase
  end

  assign out_valid     = (state == S_GOUT);
  assign gradient      = grad;
  assign mean_loss     = loss;
  assign element_index = 6'(i);
  assign last_result   = (i + CW'(1) == n);

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      count <= '0;
      tally <= '0;
      i     <= '0;
      n     <= '0;
    end else begin
      state <= state_next;
      case (state)
        S_IDLE: begin
          if (in_acc) begin
            count <= count + CW'(1);
            if (target > POS_THRESHOLD) tally <= tally + CW'(1);
            if (closing) begin
              n    <= count + CW'(1);
              i    <= '0;
              spos <= '0;
              sneg <= '0;
            end
          end
        end
        S_LD: begin
          z  <= $signed(st_rdata[31:16]);
          y  <= st_rdata[15:0];
          a  <= st_rdata[31] ? 16'(-st_rdata[31:16]) : st_rdata[31:16];
          ev <= EXP_ONE;
          k  <= '0;
        end
        S_EXP: begin
          if (!a[k]) k <= k + 4'd1;
        end
        S_EXPW: begin
          ev <= rnd16[32:16];
          k  <= k + 4'd1;
        end
        S_SIGW: begin
          lv    <= 32'(18'(ev) + 18'(EXP_ONE)) << 14;
          lbits <= '0;
          j     <= '0;
        end
        S_LNA: begin
          lv    <= sq[31] ? (sq >> 1) : sq;
          lbits <= {lbits[14:0], sq[31]};
          j     <= j + 4'd1;
        end
        S_LNR: begin
          // 1 + e reaches 2.0 exactly: log is ln 2
          ln <= (ev == EXP_ONE) ? LN2_Q16 : rnd16[31:16];
        end
        S_ZYR: begin
          if (y > POS_THRESHOLD) spos <= spos + term;
          else                   sneg <= sneg + term;
          i <= i + CW'(1);
        end
        S_LOSS: begin
          acc  <= 40'(spos) + 40'(sneg);
          lden <= 18'(n);
        end
        S_L2: begin
          acc <= spos[31] ? -$signed(mres[39:0]) : $signed(mres[39:0]);
        end
        S_L3: begin
          acc <= sneg[31] ? acc - $signed(mres[39:0]) : acc + $signed(mres[39:0]);
        end
        S_L4: begin
          lden <= {mres[16:0], 1'b0};
        end
        S_LDIV: begin
          // negative loss saturates to zero
          if (acc[39]) begin
            loss <= '0;
            i    <= '0;
          end
        end
        S_LWAIT: begin
          if (div_done) begin
            loss <= (div_quo > (DIV_NUM_W + 1)'(LOSS_MAX)) ? LOSS_MAX : div_quo[20:0];
            i    <= '0;
          end
        end
        S_GLD: begin
          dneg <= d[18];
        end
        S_GW: begin
          // magnitude never exceeds 131070, so the result fits Q2.16
          if (div_done) grad <= dneg ? -$signed(div_quo[17:0]) : $signed(div_quo[17:0]);
        end
        S_GOUT: begin
          if (out_ready) begin
            if (i + CW'(1) == n) begin
              count <= '0;
              tally <= '0;
            end else begin
              i <= i + CW'(1);
            end
          end
        end
        default: begin
        end
      endcase
    end
  end

endmodule

`default_nettype wire

// ===== hdl/bbce_ram.sv =====
// ----------------------------------------------------------------------------
// bbce_ram: generic simple dual-port RAM
// One write port, one read port, read data registered.
// ----------------------------------------------------------------------------
`default_nettype none

module bbce_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 32
) (
  input  wire logic                                     clk,
  input  wire logic                                     we,
  input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  wire logic [WIDTH-1:0]                         wdata,
  input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic      [WIDTH-1:0]                         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

// ===== hdl/bbce_div.sv =====
// ----------------------------------------------------------------------------
// bbce_div: iterative rounding divider
// Unsigned restoring divider, one quotient bit per cycle. Returns
// floor((num + den/2) / den), i.e. the quotient rounded half up.
// ----------------------------------------------------------------------------
`default_nettype none

module bbce_div
  import bbce_pkg::*;
#(
  parameter int NUM_W = 40,
  parameter int DEN_W = 18
) (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             start,
  input  wire logic [NUM_W-1:0] num,
  input  wire logic [DEN_W-1:0] den,
  output logic                  done,
  output logic [NUM_W:0]        quo
);

  localparam int QW = NUM_W + 1;
  localparam int CNT_W = $clog2(QW + 1);

  logic [CNT_W-1:0] cnt;
  logic             busy;
  logic [DEN_W-1:0] dsr;
  logic [DEN_W-1:0] rem;
  logic [DEN_W:0]   trial;
  logic             fits;

  assign trial = {rem, quo[QW-1]};
  assign fits  = (trial >= {1'b0, dsr});

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= CNT_W'(QW);
        dsr  <= den;
        rem  <= '0;
        quo  <= QW'(num) + QW'(den >> 1);
      end else if (busy) begin
        rem <= fits ? DEN_W'(trial - {1'b0, dsr}) : trial[DEN_W-1:0];
        quo <= {quo[QW-2:0], fits};
        cnt <= cnt - CNT_W'(1);
        if (cnt == CNT_W'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

endmodule

`default_nettype wire

// ===== tb/balanced_bce_logits_loss_grad_test.sv =====
// ----------------------------------------------------------------------------
// balanced_bce_logits_loss_grad_test: self-checking bench for the BCE block
// Feeds batches of logit/target pairs through a valid/ready driver, predicts
// every gradient and batch loss in fixed point, and compares each result
// transaction at the monitor under several idling phases.
// ----------------------------------------------------------------------------
`default_nettype none

module balanced_bce_logits_loss_grad_test;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int BATCH_CAP = 32;
  localparam int WATCHDOG_LIMIT = 20000;
  localparam int HOLD_CYCLES = 5000;

  typedef struct {
    logic signed [15:0] z;
    logic [15:0] y;
    logic last;
  } elem_t;

  typedef struct {
    logic signed [17:0] grad;
    logic [20:0] loss;
    logic [5:0] idx;
    logic last;
  } grad_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic in_valid = 1'b0;
  logic in_ready;
  logic signed [15:0] logit = '0;
  logic [15:0] target = '0;
  logic last_element = 1'b0;
  logic out_valid;
  logic out_ready = 1'b0;
  logic signed [17:0] gradient;
  logic [20:0] mean_loss;
  logic [5:0] element_index;
  logic last_result;

  balanced_bce_logits_loss_grad #(.MAX_BATCH(BATCH_CAP)) u_top (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_ready(in_ready),
    .logit(logit), .target(target), .last_element(last_element),
    .out_valid(out_valid), .out_ready(out_ready),
    .gradient(gradient), .mean_loss(mean_loss),
    .element_index(element_index), .last_result(last_result)
  );

  always #2 clk = ~clk;

  elem_t pending[$];
  grad_t grad_queue[$];
  elem_t batch_z[$];
  int errors = 0;
  int send_idle_pct = 0;
  int recv_stall_pct = 0;
  logic hold = 1'b0;
  int quiet_cycles = 0;

  localparam logic [15:0] EXP_TABLE [16] = '{
    16'd65520, 16'd65504, 16'd65472, 16'd65408, 16'd65280, 16'd65026,
    16'd64520, 16'd63520, 16'd61565, 16'd57835, 16'd51039, 16'd39750,
    16'd24109, 16'd8869, 16'd1200, 16'd22};

  function automatic longint round_div(longint num, longint den);
    if (num >= 0) return (num + den / 2) / den;
    return -((-num + den / 2) / den);
  endfunction

  function automatic longint exp_negq(longint a);
    longint v = 65536;
    for (int k = 0; k < 16; k++)
      if (a[k]) v = (v * EXP_TABLE[k] + 32768) >>> 16;
    return v;
  endfunction

  function automatic longint ln1p(longint e);
    logic [63:0] v;
    longint l = 0;
    v = (65536 + e) << 14;
    if (v >= 64'h8000_0000) return 45426;
    for (int i = 0; i < 16; i++) begin
      v = (v * v) >> 30;
      l = l << 1;
      if (v >= 64'h8000_0000) begin
        v = v >> 1;
        l = l | 1;
      end
    end
    return (l * 45426 + 32768) >>> 16;
  endfunction

  function automatic longint sigmoidq(longint z);
    longint e, den;
    e = exp_negq(z < 0 ? -z : z);
    den = 65536 + e;
    if (z >= 0) return ((64'sd1 <<< 32) + den / 2) / den;
    return (65536 * e + den / 2) / den;
  endfunction

  function automatic longint loss_term(longint z, longint y);
    longint sp;
    sp = ln1p(exp_negq(z < 0 ? -z : z));
    if (z > 0) sp += z * 16;
    return sp - round_div(z * y, 2048);
  endfunction

  // Accumulate the batch and, on its closing element, predict every gradient.
  task automatic predict_elem(elem_t e);
    longint n, p, q, spos, sneg, loss, d, den, g;
    bit bal;
    grad_t r;
    batch_z.push_back(e);
    if (!e.last && batch_z.size() < BATCH_CAP) return;
    n = batch_z.size();
    p = 0; spos = 0; sneg = 0;
    foreach (batch_z[i]) begin
      if (batch_z[i].y > 16384) begin
        p++;
        spos += loss_term(batch_z[i].z, batch_z[i].y);
      end else sneg += loss_term(batch_z[i].z, batch_z[i].y);
    end
    q = n - p;
    bal = p > 0 && q > 0;
    loss = bal ? round_div(spos * q + sneg * p, 2 * p * q) : round_div(spos + sneg, n);
    if (loss < 0) loss = 0;
    if (loss > 2097151) loss = 2097151;
    foreach (batch_z[i]) begin
      d = sigmoidq(batch_z[i].z) - 2 * longint'(batch_z[i].y);
      den = bal ? 2 * ((batch_z[i].y > 16384) ? p : q) : n;
      g = round_div(d, den);
      if (g > 131071) g = 131071;
      if (g < -131072) g = -131072;
      r.grad = g[17:0];
      r.loss = loss[20:0];
      r.idx = i[5:0];
      r.last = (i == n - 1);
      grad_queue.push_back(r);
    end
    batch_z.delete();
  endtask

  // driver
  always @(posedge clk) begin
    if (!rst) begin
      if (in_valid && in_ready) begin
        predict_elem(pending.pop_front());
      end
      if (!(in_valid && !in_ready)) begin
        if (pending.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
          in_valid <= 1'b1;
          logit <= pending[0].z;
          target <= pending[0].y;
          last_element <= pending[0].last;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // monitor
  always @(posedge clk) begin
    grad_t exp_r;
    if (!rst) begin
      if (out_valid && out_ready) begin
        if (grad_queue.size() == 0) begin
          $display("%0t: unexpected result idx %0d grad %0d", $time, element_index, gradient);
          errors++;
        end else begin
          exp_r = grad_queue.pop_front();
          if (gradient !== exp_r.grad) begin
            $display("%0t: gradient exp %0d got %0d", $time, exp_r.grad, gradient);
            errors++;
          end
          if (mean_loss !== exp_r.loss) begin
            $display("%0t: mean_loss exp %0d got %0d", $time, exp_r.loss, mean_loss);
            errors++;
          end
          if (element_index !== exp_r.idx) begin
            $display("%0t: element_index exp %0d got %0d", $time, exp_r.idx, element_index);
            errors++;
          end
          if (last_result !== exp_r.last) begin
            $display("%0t: last_result exp %0d got %0d", $time, exp_r.last, last_result);
            errors++;
          end
        end
      end
      if (hold) begin
        out_ready <= 1'b0;
      end else begin
        out_ready <= ($urandom_range(99) >= recv_stall_pct);
      end
      if ((in_valid && in_ready) || (out_valid && out_ready)) quiet_cycles <= 0;
      else quiet_cycles <= quiet_cycles + 1;
    end
  end

  // long receiver stall once the stalling phase begins, sender still offering
  initial begin
    wait (recv_stall_pct != 0);
    @(posedge clk);
    hold <= 1'b1;
    repeat (HOLD_CYCLES) @(posedge clk);
    hold <= 1'b0;
  end

  // watchdog
  always @(posedge clk) begin
    if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("balanced_bce_logits_loss_grad_test NOT OK");
      $finish;
    end
  end

  function automatic logic [15:0] rand_target();
    case ($urandom_range(5))
      0: return 16'd0;
      1: return 16'd32768;
      2: return 16'd16384 + 16'($urandom_range(1));
      3: return 16'($urandom);
      default: return 16'($urandom_range(32768));
    endcase
  endfunction

  task automatic add_elem(logic signed [15:0] z, logic [15:0] y, logic last);
    elem_t e;
    e.z = z; e.y = y; e.last = last;
    pending.push_back(e);
  endtask

  task automatic add_batch(int n);
    for (int i = 0; i < n; i++)
      add_elem(16'($urandom), rand_target(), i == n - 1);
  endtask

  task automatic drain();
    while (pending.size() > 0 || grad_queue.size() > 0) @(posedge clk);
  endtask

  initial begin
    repeat (2) @(posedge clk);
    rst <= 1'b0;
    // directed: extremes, both classes, single class, odd targets
    add_elem(16'sh8000, 16'd0, 1'b0);
    add_elem(16'sh7FFF, 16'd32768, 1'b0);
    add_elem(16'sd0, 16'd16384, 1'b0);
    add_elem(16'sd0, 16'd16385, 1'b0);
    add_elem(-16'sd1, 16'hFFFF, 1'b0);
    add_elem(16'sd1, 16'd32769, 1'b1);
    add_elem(16'sh7FFF, 16'd0, 1'b1);
    add_elem(16'sh8000, 16'd32768, 1'b0);
    add_elem(16'sh8000, 16'hFFFF, 1'b1);
    add_elem(16'sh7FFF, 16'hFFFF, 1'b0);
    add_elem(16'sh8000, 16'd0, 1'b1);
    add_batch(2);
    drain();
    // full batch closes without a last flag
    for (int i = 0; i < BATCH_CAP; i++) add_elem(16'($urandom), rand_target(), 1'b0);
    add_batch(3);
    drain();
    for (int ph = 0; ph < 4; ph++) begin
      send_idle_pct = (ph == 1 || ph == 3) ? (ph == 1 ? 58 : 27) : 0;
      recv_stall_pct = (ph == 2) ? 58 : (ph == 3 ? 27 : 0);
      for (int b = 0; b < 11; b++) begin
        int n;
        n = ($urandom_range(9) == 0) ? $urandom_range(BATCH_CAP, 20) : $urandom_range(8, 1);
        add_batch(n);
      end
      drain();
    end
    repeat (200) @(posedge clk);
    if (errors == 0 && grad_queue.size() == 0) begin
      $display("balanced_bce_logits_loss_grad_test OK");
    end else begin
      $display("balanced_bce_logits_loss_grad_test NOT OK");
    end
    $finish;
  end

endmodule

`default_nettype wire
